// File: src/assert_macros.svh
// Assertion helpers used by the resampler datapath RTL.
// Every macro samples on clk and holds off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PRR_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PRR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg
// Shared constants, codes and controller/datapath types of the resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

	localparam int HISTORY_DEPTH = 32;
	localparam int MAX_BRANCHES  = 16;
	localparam int COEFF_DEPTH   = 512;
	localparam int MAX_RESULTS   = 16;
	localparam int MAX_DECIMATE  = 255;
	localparam int MAX_NEEDED    = 255;
	localparam int OUT_SHIFT     = 15;

	localparam int SAMPLE_W   = 16;
	localparam int ACC_W      = 32;
	localparam int FUNC_W     = 2;
	localparam int BR_W       = 5;
	localparam int DEC_W      = 8;
	localparam int HLEN_W     = 6;
	localparam int NEED_W     = 8;
	localparam int HIST_AW    = $clog2(HISTORY_DEPTH);
	localparam int TAP_W      = $clog2(HISTORY_DEPTH + 1);
	localparam int COEFF_AW   = $clog2(COEFF_DEPTH);
	localparam int PHASE_W    = $clog2(MAX_BRANCHES);
	localparam int PACC_W     = $clog2(MAX_BRANCHES + MAX_DECIMATE);
	localparam int RES_W      = $clog2(MAX_RESULTS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [BR_W-1:0]   BRANCHES_RST = BR_W'(9);
	localparam logic [DEC_W-1:0]  DECIMATE_RST = DEC_W'(10);
	localparam logic [HLEN_W-1:0] HLEN_RST     = HLEN_W'(30);

	localparam logic [CFG_IDX_W-1:0] CFG_BRANCHES = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DECIMATE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_HLEN     = CFG_IDX_W'(2);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH    = 2'd0,
		FUNC_COEFF   = 2'd1,
		FUNC_RESTART = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC_INIT,
		ST_MAC,
		ST_DIV,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic push;
		logic coeff_wr;
		logic restart;
		logic run_start;
		logic mac_init;
		logic step_init;
		logic div_sub;
		logic div_commit;
		logic out_load;
	} prr_cmd_t;

	typedef struct packed {
		logic need_le1;
		logic mac_done;
		logic div_ge;
		logic out_free;
		logic run_last;
	} prr_stat_t;

endpackage

// File: src/prr_in_if.sv
// ----------------------------------------------------------------------------
// prr_in_if
// Input channel: one beat carries a command code and its operands.
// ----------------------------------------------------------------------------
interface prr_in_if;
	import prr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [FUNC_W-1:0]          func;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [COEFF_AW-1:0]        coeff_index;
	logic signed [SAMPLE_W-1:0] coeff_value;

	modport source (output valid, func, sample_in, coeff_index, coeff_value, input ready);
	modport sink (input valid, func, sample_in, coeff_index, coeff_value, output ready);
endinterface

// File: src/prr_out_if.sv
// ----------------------------------------------------------------------------
// prr_out_if
// Output channel: one beat carries one resampled value.
// ----------------------------------------------------------------------------
interface prr_out_if;
	import prr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] filtered_sample;
	logic                       last_of_run;

	modport source (output valid, filtered_sample, last_of_run, input ready);
	modport sink (input valid, filtered_sample, last_of_run, output ready);
endinterface

// File: src/prr_ctrl.sv
// ----------------------------------------------------------------------------
// prr_ctrl
// Sequencer: decodes input beats and steps the datapath through MAC,
// phase step and output load for every result of a push.
// ----------------------------------------------------------------------------
module prr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [prr_pkg::FUNC_W-1:0]  in_func,
	input  prr_pkg::prr_stat_t          stat,
	output prr_pkg::prr_cmd_t           cmd
);
	import prr_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_func)
						FUNC_PUSH: begin
							cmd.push = 1'b1;
							if (stat.need_le1) begin
								cmd.run_start = 1'b1;
								state_d       = ST_MAC_INIT;
							end
						end
						FUNC_COEFF:   cmd.coeff_wr = 1'b1;
						FUNC_RESTART: cmd.restart  = 1'b1;
						default:      ;
					endcase
				end
			end
			ST_MAC_INIT: begin
				cmd.mac_init = 1'b1;
				state_d      = ST_MAC;
			end
			ST_MAC: begin
				if (stat.mac_done) begin
					cmd.step_init = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_ge) begin
					cmd.div_sub = 1'b1;
				end else begin
					cmd.div_commit = 1'b1;
					state_d        = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = stat.run_last ? ST_IDLE : ST_MAC_INIT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: src/prr_dp.sv
// ----------------------------------------------------------------------------
// prr_dp
// Datapath: configuration registers, sample history, coefficient RAM,
// three-stage MAC, iterative phase step and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [prr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [prr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [prr_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [prr_pkg::COEFF_AW-1:0]        coeff_index,
	input  logic signed [prr_pkg::SAMPLE_W-1:0] coeff_value,
	input  prr_pkg::prr_cmd_t                   cmd,
	output prr_pkg::prr_stat_t                  stat,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [prr_pkg::SAMPLE_W-1:0] filtered_sample,
	output logic                                last_of_run
);
	import prr_pkg::*;

	// configuration
	logic [BR_W-1:0]   branches_q;
	logic [DEC_W-1:0]  decimate_q;
	logic [HLEN_W-1:0] hist_len_q;
	logic [BR_W-1:0]   br_eff;
	logic [DEC_W-1:0]  dec_eff;
	logic [TAP_W-1:0]  hlen_eff;
	logic [HIST_AW-1:0] hlen_m1;

	// filter state
	logic signed [SAMPLE_W-1:0] hist_q [HISTORY_DEPTH];
	logic signed [SAMPLE_W-1:0] coeff_mem [COEFF_DEPTH];
	logic [PHASE_W-1:0]  phase_q;
	logic [HIST_AW-1:0]  write_index_q;
	logic [NEED_W-1:0]   samples_needed_q;
	logic [TAP_W-1:0]    wr_next;
	logic [HIST_AW-1:0]  wr_new;
	logic [TAP_W-1:0]    wr_taps;
	logic [TAP_W-1:0]    tap_count;

	// MAC
	logic [HIST_AW-1:0]  rd_idx_q;
	logic [COEFF_AW-1:0] addr_q;
	logic [TAP_W-1:0]    taps_left_q;
	logic                issue;
	logic                v_s1, v_s2;
	logic signed [SAMPLE_W-1:0] hist_s1, coeff_s1;
	logic signed [ACC_W-1:0]    prod_s2;
	logic signed [ACC_W-1:0]    acc_q;

	// phase step
	logic [PACC_W-1:0] phase_acc_q;
	logic [PACC_W-1:0] need_cnt_q;
	logic [RES_W-1:0]  run_cnt_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;
	logic                       out_last_q;

	always_comb begin
		if (branches_q == '0)
			br_eff = BR_W'(1);
		else if (branches_q > BR_W'(MAX_BRANCHES))
			br_eff = BR_W'(MAX_BRANCHES);
		else
			br_eff = branches_q;
		dec_eff = (decimate_q == '0) ? DEC_W'(1) : decimate_q;
		if (hist_len_q == '0)
			hlen_eff = TAP_W'(1);
		else if (hist_len_q > HLEN_W'(HISTORY_DEPTH))
			hlen_eff = TAP_W'(HISTORY_DEPTH);
		else
			hlen_eff = TAP_W'(hist_len_q);
	end

	assign hlen_m1 = HIST_AW'(hlen_eff - TAP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			branches_q <= BRANCHES_RST;
			decimate_q <= DECIMATE_RST;
			hist_len_q <= HLEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BRANCHES: branches_q <= cfg_data[BR_W-1:0];
				CFG_DECIMATE: decimate_q <= cfg_data[DEC_W-1:0];
				CFG_HLEN:     hist_len_q <= cfg_data[HLEN_W-1:0];
				default:      ;
			endcase
		end
	end

	// advance the write pointer, wrap at the history length
	assign wr_next = TAP_W'(write_index_q) + TAP_W'(1);
	assign wr_new  = (wr_next < hlen_eff && wr_next < TAP_W'(HISTORY_DEPTH)) ?
		HIST_AW'(wr_next) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
		end else if (cmd.restart) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
		end else if (cmd.push) begin
			hist_q[wr_new] <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q    <= '0;
			phase_q          <= '0;
			samples_needed_q <= NEED_W'(1);
		end else if (cmd.restart) begin
			write_index_q    <= '0;
			phase_q          <= '0;
			samples_needed_q <= NEED_W'(1);
		end else begin
			if (cmd.push) begin
				write_index_q    <= wr_new;
				samples_needed_q <= stat.need_le1 ? '0 : samples_needed_q - NEED_W'(1);
			end
			if (cmd.div_commit) begin
				phase_q          <= phase_acc_q[PHASE_W-1:0];
				samples_needed_q <= (need_cnt_q > PACC_W'(MAX_NEEDED)) ?
					NEED_W'(MAX_NEEDED) : need_cnt_q[NEED_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.coeff_wr) coeff_mem[coeff_index] <= coeff_value;
	end

	// taps: newest back to slot zero, then from the far end down
	assign wr_taps   = TAP_W'(write_index_q) + TAP_W'(1);
	assign tap_count = (wr_taps > hlen_eff) ? wr_taps : hlen_eff;
	assign issue     = taps_left_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_left_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (cmd.mac_init)
				taps_left_q <= tap_count;
			else if (issue)
				taps_left_q <= taps_left_q - TAP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_init) begin
			rd_idx_q <= write_index_q;
			addr_q   <= COEFF_AW'(phase_q);
		end else if (issue) begin
			rd_idx_q <= (rd_idx_q == '0) ? hlen_m1 : rd_idx_q - HIST_AW'(1);
			addr_q   <= addr_q + COEFF_AW'(br_eff);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			hist_s1  <= hist_q[rd_idx_q];
			coeff_s1 <= coeff_mem[addr_q];
		end
		prod_s2 <= hist_s1 * coeff_s1;
		if (cmd.mac_init)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + prod_s2;
	end

	// phase step by repeated subtraction of the branch count
	always_ff @(posedge clk) begin
		if (cmd.step_init) begin
			phase_acc_q <= PACC_W'(phase_q) + PACC_W'(dec_eff);
			need_cnt_q  <= '0;
		end else if (cmd.div_sub) begin
			phase_acc_q <= phase_acc_q - PACC_W'(br_eff);
			need_cnt_q  <= need_cnt_q + PACC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (cmd.run_start) begin
			run_cnt_q <= '0;
		end else if (cmd.out_load) begin
			run_cnt_q <= run_cnt_q + RES_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= acc_q[OUT_SHIFT +: SAMPLE_W];
			out_last_q <= stat.run_last;
		end
	end

	always_comb begin
		stat.need_le1 = samples_needed_q <= NEED_W'(1);
		stat.mac_done = !issue && !v_s1 && !v_s2;
		stat.div_ge   = phase_acc_q >= PACC_W'(br_eff);
		stat.out_free = !out_valid_q || out_ready;
		stat.run_last = (samples_needed_q != '0) || (run_cnt_q == RES_W'(MAX_RESULTS - 1));
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = out_data_q;
	assign last_of_run     = out_last_q;

	`PRR_ASSERT_SAME(a_mac_init_empty, cmd.mac_init, !issue && !v_s1 && !v_s2, "MAC restarted with taps in flight")
	`PRR_ASSERT_NEXT(a_mac_has_taps, cmd.mac_init, taps_left_q != '0, "MAC started with no taps")
	`PRR_ASSERT_SAME(a_phase_reduced, cmd.div_commit, phase_acc_q < PACC_W'(br_eff), "phase committed before reduction")
	`PRR_ASSERT_SAME(a_run_cap, cmd.out_load && run_cnt_q == RES_W'(MAX_RESULTS - 1), stat.run_last, "run exceeded result cap")

endmodule

// File: src/polyphase_rational_resampler.sv
// ----------------------------------------------------------------------------
// polyphase_rational_resampler: polyphase FIR resampler, branches up, decimate down.
// A coefficient write, restart, ignored code or push with no result stays in idle.
// A push yielding k results runs MAC, phase step and output load k times: each
// result takes T = max(write slot+1, history length) taps through the single MAC and
// N = (phase+decimate)/branches subtraction steps; a held beat stalls the next result.
// Reset (arst_n low) clears history, phase and counters at once; no clearing pass.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler (
	input  logic                               clk,
	input  logic                               arst_n,
	prr_in_if.sink                             in_ch,
	prr_out_if.source                          out_ch,
	input  logic                               cfg_we,
	input  logic [prr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import prr_pkg::*;

	// Control and status between sequencer and datapath
	prr_cmd_t  cmd;
	prr_stat_t stat;

	// Sequencer: takes input beats only in idle, one item at a time.
	// A push walks MAC -> phase step -> output load once per result,
	// and stops after the result that leaves samples still needed
	// or after the sixteenth result of the run.
	prr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_func  (in_ch.func),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: history flops, coefficient RAM with registered read,
	// read -> multiply -> accumulate pipeline, and the output register
	// that holds a finished beat while the sink stalls.
	prr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_in       (in_ch.sample_in),
		.coeff_index     (in_ch.coeff_index),
		.coeff_value     (in_ch.coeff_value),
		.cmd             (cmd),
		.stat            (stat),
		.out_ready       (out_ch.ready),
		.out_valid       (out_ch.valid),
		.filtered_sample (out_ch.filtered_sample),
		.last_of_run     (out_ch.last_of_run)
	);

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for polyphase_rational_resampler
// Loads every coefficient, then walks a short directed table under the reset
// ratio and a series of random phases under new ratios. A behavioral copy of
// the resampler predicts every output beat. A monitor compares each output
// beat with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
	import prr_pkg::*;

	// Code that the block must drop without an output.
	localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
	// Register index with no register behind it.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// Idle cycles after the last output before the ratio changes, and at the end.
	localparam int SETTLE_CYCLES = 400;
	// Each random phase runs until at least this many outputs are predicted.
	localparam int MIN_PHASE_OUTPUTS = 6;
	localparam int DIRECTED_ROWS = 20;

	typedef struct packed {
		logic [FUNC_W-1:0]          func;
		logic signed [SAMPLE_W-1:0] sample;
		logic [COEFF_AW-1:0]        idx;
		logic signed [SAMPLE_W-1:0] coeff;
		logic                       typed;
		logic signed [SAMPLE_W-1:0] want;
	} stim_row_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last_of_run;
	} outcome_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	prr_in_if  in_ch ();
	prr_out_if out_ch ();

	polyphase_rational_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Behavioral copy of the resampler state and registers.
	logic [BR_W-1:0]            br_reg;
	logic [DEC_W-1:0]           dec_reg;
	logic [HLEN_W-1:0]          hlen_reg;
	logic signed [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
	logic signed [SAMPLE_W-1:0] coeff_mem [COEFF_DEPTH];
	int                         phase_acc;
	int                         wr_slot;
	int                         need_cnt;

	outcome_t pending_outputs [$];
	outcome_t head_out;
	int       results_predicted;
	int       fail_count;
	bit       calm;
	int       stall_left;

	// Directed rows run under the reset ratio (9 up, 10 down, 30 taps).
	// Right after a restart the history is zero, so the first push yields a
	// single output equal to sample * coeff[0] >> 15; those rows carry the
	// answer by hand. All other rows go through the predictor.
	stim_row_t stim_table [DIRECTED_ROWS] = '{
		'{FUNC_COEFF,   16'sh0000, 9'd0,   16'sh8000, 1'b0, 16'sh0000},
		'{FUNC_COEFF,   16'sh0000, 9'd511, 16'sh7FFF, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh8000, 9'd0,   16'sh0000, 1'b1, 16'sh8000},
		'{FUNC_RESTART, 16'sh0000, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh7FFF, 9'd0,   16'sh0000, 1'b1, 16'sh8001},
		'{FUNC_IGNORED, 16'sh7FFF, 9'd511, 16'sh7FFF, 1'b0, 16'sh0000},
		'{FUNC_RESTART, 16'shFFFF, 9'd511, 16'shFFFF, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh0000, 9'd0,   16'sh0000, 1'b1, 16'sh0000},
		'{FUNC_PUSH,    16'sh0001, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'shFFFF, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh5555, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'shAAAA, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_COEFF,   16'sh0000, 9'd9,   16'sh7FFF, 1'b0, 16'sh0000},
		'{FUNC_COEFF,   16'sh0000, 9'd256, 16'sh0001, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh7FFF, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh8000, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh3039, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_IGNORED, 16'sh0000, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh8000, 9'd0,   16'sh0000, 1'b0, 16'sh0000},
		'{FUNC_PUSH,    16'sh7FFF, 9'd0,   16'sh0000, 1'b0, 16'sh0000}
	};

	task automatic flag_error(input string msg);
		fail_count++;
		if (fail_count <= 50)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// Mostly back to back, sometimes a few cycles, rarely a long hole.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void restart_filter();
		for (int i = 0; i < HISTORY_DEPTH; i++)
			hist_mem[i] = '0;
		phase_acc = 0;
		wr_slot = 0;
		need_cnt = 1;
	endfunction

	// One output: history newest first, wrapping back from the top of the
	// active window, against the taps of the current phase. 32-bit wrapping
	// sum, then bits 30:15.
	function automatic logic signed [SAMPLE_W-1:0] fir_output(input int br, input int hl);
		bit [ACC_W-1:0] acc;
		int             w;
		int             n_taps;
		int             slot;
		int             addr;
		acc = '0;
		w = (wr_slot >= HISTORY_DEPTH) ? HISTORY_DEPTH - 1 : wr_slot;
		n_taps = (hl > w + 1) ? hl : w + 1;
		addr = phase_acc;
		for (int j = 0; j < n_taps; j++) begin
			slot = (j <= w) ? w - j : hl + w - j;
			if (addr < COEFF_DEPTH)
				acc += ACC_W'(int'(hist_mem[slot]) * int'(coeff_mem[addr]));
			addr += br;
		end
		return acc[OUT_SHIFT+SAMPLE_W-1:OUT_SHIFT];
	endfunction

	// Apply one accepted input beat to the behavioral copy and queue the
	// output beats that it causes.
	function automatic void resample_beat(input logic [FUNC_W-1:0] f,
			input logic signed [SAMPLE_W-1:0] s, input logic [COEFF_AW-1:0] idx,
			input logic signed [SAMPLE_W-1:0] v);
		int       br;
		int       dec;
		int       hl;
		int       nxt;
		int       need;
		int       n;
		outcome_t o;
		case (f)
			FUNC_COEFF: begin
				coeff_mem[idx] = v;
			end
			FUNC_RESTART: begin
				restart_filter();
			end
			FUNC_PUSH: begin
				// Out-of-range register values clamp.
				br = (br_reg == 0) ? 1 : (br_reg > MAX_BRANCHES) ? MAX_BRANCHES : int'(br_reg);
				dec = (dec_reg == 0) ? 1 : int'(dec_reg);
				hl = (hlen_reg == 0) ? 1 :
					(hlen_reg > HISTORY_DEPTH) ? HISTORY_DEPTH : int'(hlen_reg);
				nxt = wr_slot + 1;
				wr_slot = (nxt < hl && nxt < HISTORY_DEPTH) ? nxt : 0;
				hist_mem[wr_slot] = s;
				if (need_cnt > 1) begin
					need_cnt--;
				end else begin
					need_cnt = 0;
					n = 0;
					// Keep producing while the phase stays inside the branch range, up to the result cap.
					while (need_cnt == 0 && n < MAX_RESULTS) begin
						o.value = fir_output(br, hl);
						phase_acc += dec;
						need = 0;
						while (phase_acc >= br) begin
							phase_acc -= br;
							need++;
						end
						need_cnt = (need > MAX_NEEDED) ? MAX_NEEDED : need;
						n++;
						o.last_of_run = (need_cnt != 0 || n == MAX_RESULTS);
						pending_outputs.push_back(o);
						results_predicted++;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Drive one input beat and hold it until the block takes it. Called right
	// after a rising edge; returns right after the accepting edge.
	task automatic send_beat(input logic [FUNC_W-1:0] f, input logic signed [SAMPLE_W-1:0] s,
			input logic [COEFF_AW-1:0] idx, input logic signed [SAMPLE_W-1:0] v,
			input bit hold_for_drain);
		int gap;
		gap = pick_gap();
		if (hold_for_drain || gap != 0) begin
			// Drop valid before raising it again so it is not lowered and raised
			// in the same step.
			in_ch.valid <= 1'b0;
			if (gap == 0)
				gap = 1;
			while (hold_for_drain && pending_outputs.size() != 0)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.func        <= f;
		in_ch.sample_in   <= s;
		in_ch.coeff_index <= idx;
		in_ch.coeff_value <= v;
		do @(posedge clk); while (!in_ch.ready);
		resample_beat(f, s, idx, v);
	endtask

	// Drop valid, wait for every predicted output, then let the block finish
	// any trailing work before a register write or the end of the run.
	task automatic settle_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_outputs.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the three ratio registers back to back, and optionally poke the
	// unused index, which the block must ignore.
	task automatic write_ratio(input logic [CFG_DATA_W-1:0] br_val,
			input logic [CFG_DATA_W-1:0] dec_val, input logic [CFG_DATA_W-1:0] hl_val,
			input bit poke_spare);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BRANCHES;
		cfg_data  <= br_val;
		@(posedge clk);
		cfg_index <= CFG_DECIMATE;
		cfg_data  <= dec_val;
		@(posedge clk);
		cfg_index <= CFG_HLEN;
		cfg_data  <= hl_val;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= CFG_SPARE;
			cfg_data  <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		br_reg   = br_val[BR_W-1:0];
		dec_reg  = dec_val[DEC_W-1:0];
		hlen_reg = hl_val[HLEN_W-1:0];
	endtask

	// Random traffic under one ratio: mostly pushes with random content, some
	// coefficient rewrites, a few restarts and dropped codes.
	task automatic run_random_phase(input logic [CFG_DATA_W-1:0] br_val,
			input logic [CFG_DATA_W-1:0] dec_val, input logic [CFG_DATA_W-1:0] hl_val,
			input bit poke_spare, input int quota);
		int                         taken;
		int                         start_results;
		int                         r;
		logic [FUNC_W-1:0]          f;
		logic signed [SAMPLE_W-1:0] s;
		settle_idle();
		write_ratio(br_val, dec_val, hl_val, poke_spare);
		calm = ($urandom_range(0, 3) == 0);
		taken = 0;
		start_results = results_predicted;
		while (taken < quota || results_predicted - start_results < MIN_PHASE_OUTPUTS) begin
			r = $urandom_range(0, 99);
			f = (r < 82) ? FUNC_PUSH : (r < 92) ? FUNC_COEFF :
				(r < 96) ? FUNC_RESTART : FUNC_IGNORED;
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: s = 16'sh8000;
					1: s = 16'sh7FFF;
					2: s = 16'sh0000;
					default: s = 16'shFFFF;
				endcase
			end else begin
				s = SAMPLE_W'($urandom);
			end
			// Halfway through, and now and then at random, hold the sender until the output side drains.
			send_beat(f, s, COEFF_AW'($urandom), SAMPLE_W'($urandom),
				taken == quota / 2 || $urandom_range(0, 39) == 0);
			if (f != FUNC_IGNORED)
				taken++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Output side: accept with random stalls, or without any in a calm phase.
	initial begin
		out_ch.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Compare every output beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				flag_error($sformatf("output %0d with nothing pending",
					out_ch.filtered_sample));
			end else begin
				head_out = pending_outputs.pop_front();
				if (out_ch.filtered_sample !== head_out.value)
					flag_error($sformatf("filtered_sample got %0d want %0d",
						out_ch.filtered_sample, head_out.value));
				if (out_ch.last_of_run !== head_out.last_of_run)
					flag_error($sformatf("last_of_run got %0b want %0b",
						out_ch.last_of_run, head_out.last_of_run));
			end
		end
	end

	// Main sequence.
	initial begin
		outcome_t tail_out;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_BRANCHES;
		cfg_data          <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.func        <= FUNC_PUSH;
		in_ch.sample_in   <= '0;
		in_ch.coeff_index <= '0;
		in_ch.coeff_value <= '0;
		fail_count = 0;
		results_predicted = 0;
		calm = 1'b0;
		br_reg   = BRANCHES_RST;
		dec_reg  = DECIMATE_RST;
		hlen_reg = HLEN_RST;
		restart_filter();
		for (int i = 0; i < COEFF_DEPTH; i++)
			coeff_mem[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole coefficient memory so no tap ever reads an unwritten word.
		for (int i = 0; i < COEFF_DEPTH; i++)
			send_beat(FUNC_COEFF, SAMPLE_W'($urandom), COEFF_AW'(i), SAMPLE_W'($urandom), 1'b0);

		// Directed rows under the reset ratio. Rows with a typed answer
		// replace the predicted value of their single output beat.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_beat(stim_table[i].func, stim_table[i].sample, stim_table[i].idx,
				stim_table[i].coeff, i == 11);
			if (stim_table[i].typed) begin
				tail_out = pending_outputs.pop_back();
				tail_out.value = stim_table[i].want;
				pending_outputs.push_back(tail_out);
			end
		end

		// Max branches with unit step: 16 outputs per push over 32 taps.
		run_random_phase(8'd16, 8'd1, 8'd32, 1'b0, 35);
		// Largest step: outputs are sparse, one per sixteen or so pushes.
		run_random_phase(8'd16, 8'd255, 8'd1, 1'b0, 20);
		// Zero in every register: each clamps to one.
		run_random_phase(8'd0, 8'd0, 8'd0, 1'b0, 30);
		// Oversized branches and taps clamp to the top; poke the spare index too.
		run_random_phase(8'd31, 8'd7, 8'd63, 1'b1, 30);
		// Upper data bits set: only the low bits of each register count.
		run_random_phase(8'hE5, 8'd3, 8'hC7, 1'b0, 30);
		// Two random ratios.
		run_random_phase(CFG_DATA_W'($urandom_range(1, 16)), CFG_DATA_W'($urandom_range(1, 24)),
			CFG_DATA_W'($urandom_range(1, 32)), 1'b0, 35);
		run_random_phase(CFG_DATA_W'($urandom_range(1, 16)), CFG_DATA_W'($urandom_range(1, 24)),
			CFG_DATA_W'($urandom_range(1, 32)), 1'b0, 35);

		settle_idle();
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#400_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
